>>> rtl/ctwm_pkg.sv
// ----------------------------------------------------------------------------
// ctwm_pkg: shared types and constants for the cassette waveform modulator
// Command codes, speed modes, run lengths and the descriptor that the
// front end passes to the run sequencer.
// ----------------------------------------------------------------------------
package ctwm_pkg;

	// command codes on the input channel
	typedef enum logic [1:0] {
		CMD_BYTE    = 2'd0,
		CMD_ZERO    = 2'd1,
		CMD_SILENCE = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	// speed modes; code three behaves as the 11025 Hz mode
	localparam logic [1:0] MODE_4800  = 2'd0;
	localparam logic [1:0] MODE_8000  = 2'd1;
	localparam logic [1:0] MODE_11025 = 2'd2;
	localparam logic [1:0] MODE_RESET = MODE_11025;

	localparam int MAX_ZERO_BITS   = 32;
	localparam int SILENCE_SAMPLES = 15000;
	localparam int RUN_MAX         = 16383;

	localparam int LEN_W   = 14;
	localparam int TOTAL_W = 32;
	localparam int LEVEL_W = 8;
	localparam int CNT_W   = 6;
	localparam int FRAME_W = 11;   // two start bits, eight data bits, stop bit

	// work queue between front end and sequencer; depth is a power of two
	localparam int WQ_DEPTH = 2;
	localparam int WQ_PTR_W = $clog2(WQ_DEPTH);
	localparam int WQ_CNT_W = $clog2(WQ_DEPTH + 1);

	localparam logic [LEVEL_W-1:0] LEVEL_SILENCE = 8'h80;
	localparam logic [LEVEL_W-1:0] LEVEL_RESET   = 8'hC0;

	localparam logic [CNT_W-1:0] MAX_ZERO_BITS_C = CNT_W'(MAX_ZERO_BITS);
	localparam logic [CNT_W-1:0] FRAME_BITS_C    = CNT_W'(FRAME_W);

	// silence is split into full runs plus a remainder run
	localparam int SIL_FULL   = SILENCE_SAMPLES / RUN_MAX;
	localparam int SIL_REM    = SILENCE_SAMPLES % RUN_MAX;
	localparam int SIL_RUNS   = SIL_FULL + ((SIL_REM != 0) ? 1 : 0);
	localparam int SIL_CNT_W  = $clog2(SIL_RUNS + 1);
	localparam logic [LEN_W-1:0] RUN_MAX_LEN = LEN_W'(RUN_MAX);
	localparam logic [LEN_W-1:0] SIL_REM_LEN = LEN_W'(SIL_REM);

	// work item handed from front end to sequencer
	typedef struct packed {
		logic               is_sil;
		logic [FRAME_W-1:0] frame;   // bits sent LSB first, zeros beyond
		logic [CNT_W-1:0]   nbits;   // bits to send, 1..MAX_ZERO_BITS
	} desc_t;

	// half-cycle length in samples
	function automatic logic [LEN_W-1:0] half_len(input logic [1:0] mode,
	                                             input logic one,
	                                             input logic second);
		logic [LEN_W-1:0] len;
		case (mode)
			MODE_4800: len = (!second) ? LEN_W'(1) : (one ? LEN_W'(1) : LEN_W'(2));
			MODE_8000: begin
				if (!second) len = one ? LEN_W'(1) : LEN_W'(2);
				else         len = one ? LEN_W'(2) : LEN_W'(3);
			end
			default: begin
				if (!second) len = one ? LEN_W'(2) : LEN_W'(3);
				else         len = one ? LEN_W'(2) : LEN_W'(4);
			end
		endcase
		return len;
	endfunction

endpackage

>>> rtl/cassette_tape_waveform_modulator.sv
// ----------------------------------------------------------------------------
// cassette_tape_waveform_modulator: command to sample-run encoder
// Turns framed bytes, zero-bit runs and silence into runs of 8-bit samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue (push/full): an item is cmd, byte_value, bit_count; it is
//   taken at an edge with push high and full low. A byte becomes 22 runs,
//   a zero-bit command 2*n runs (n saturated at 32), silence one run at 0x80.
//   Command three and a zero bit count are taken and produce nothing.
//   Result queue (empty/pop): while empty is low the oldest run is on
//   sample_level, run_samples, sample_total, last; pop takes it. last marks
//   the final run of an item.
//   Config (cfg_valid/cfg_ready/cfg_data): speed mode, always ready; write
//   only while the block is idle. Reset value is the 11025 Hz mode.
// Timing:
//   The front end queues up to two items. The sequencer loads an item, then
//   gives one run per cycle while pop keeps up. An accepted item is written
//   to the work queue, loaded by the sequencer, then its first run is registered.
//   The single output register sets the pace: a stalled pop freezes the
//   sequencer and then fills the work queue, raising full.
// Reset (arst_n low): queues empty, level state 0xC0 so the first half-cycle
//   is 0x40, sample total zero.
// ----------------------------------------------------------------------------
module cassette_tape_waveform_modulator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  cmd,
	input  logic [7:0]  byte_value,
	input  logic [5:0]  bit_count,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  sample_level,
	output logic [13:0] run_samples,
	output logic [31:0] sample_total,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data
);
	import ctwm_pkg::*;

	logic [1:0] speed_mode_q;
	logic       desc_valid, desc_take;
	desc_t      desc;

	// config register, written any cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_mode_q <= MODE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			speed_mode_q <= cfg_data;
		end
	end

	ctwm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.cmd        (cmd),
		.byte_value (byte_value),
		.bit_count  (bit_count),
		.desc_valid (desc_valid),
		.desc       (desc),
		.desc_take  (desc_take)
	);

	ctwm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.speed_mode   (speed_mode_q),
		.desc_valid   (desc_valid),
		.desc         (desc),
		.desc_take    (desc_take),
		.empty        (empty),
		.pop          (pop),
		.sample_level (sample_level),
		.run_samples  (run_samples),
		.sample_total (sample_total),
		.last         (last)
	);

endmodule

>>> rtl/ctwm_front.sv
// ----------------------------------------------------------------------------
// ctwm_front: command intake and work queue
// Accepts commands, drops those that make no runs, builds the bit frame and
// holds up to two work items for the sequencer.
// ----------------------------------------------------------------------------
module ctwm_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [1:0]              cmd,
	input  logic [7:0]              byte_value,
	input  logic [ctwm_pkg::CNT_W-1:0] bit_count,
	output logic                    desc_valid,
	output ctwm_pkg::desc_t         desc,
	input  logic                    desc_take
);
	import ctwm_pkg::*;

	desc_t                q_mem [WQ_DEPTH];
	logic [WQ_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [WQ_CNT_W-1:0]  count_q;
	logic                 accept, keep, wr_en, rd_en;
	desc_t                new_desc;

	assign full   = (count_q == WQ_CNT_W'(WQ_DEPTH));
	assign accept = push && !full;

	always_comb begin
		keep     = 1'b0;
		new_desc = '0;
		case (cmd_t'(cmd))
			CMD_BYTE: begin
				keep           = 1'b1;
				new_desc.frame = {1'b0, byte_value, 2'b11};
				new_desc.nbits = FRAME_BITS_C;
			end
			CMD_ZERO: begin
				keep           = (bit_count != '0);
				new_desc.nbits = (bit_count > MAX_ZERO_BITS_C) ? MAX_ZERO_BITS_C : bit_count;
			end
			CMD_SILENCE: begin
				keep            = 1'b1;
				new_desc.is_sil = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign wr_en      = accept && keep;
	assign desc_valid = (count_q != '0);
	assign rd_en      = desc_take && desc_valid;
	assign desc       = q_mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + WQ_PTR_W'(1);
			if (rd_en) rd_ptr_q <= rd_ptr_q + WQ_PTR_W'(1);
			count_q <= count_q + WQ_CNT_W'(wr_en) - WQ_CNT_W'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) q_mem[wr_ptr_q] <= new_desc;
	end

endmodule

>>> rtl/ctwm_back.sv
// ----------------------------------------------------------------------------
// ctwm_back: run sequencer
// Walks one work item into level runs in a single output register, one run per
// cycle unless pop stalls. Holds half-cycle level and running sample total.
// ----------------------------------------------------------------------------
module ctwm_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [1:0]                  speed_mode,
	input  logic                        desc_valid,
	input  ctwm_pkg::desc_t             desc,
	output logic                        desc_take,
	output logic                        empty,
	input  logic                        pop,
	output logic [ctwm_pkg::LEVEL_W-1:0] sample_level,
	output logic [ctwm_pkg::LEN_W-1:0]   run_samples,
	output logic [ctwm_pkg::TOTAL_W-1:0] sample_total,
	output logic                        last
);
	import ctwm_pkg::*;

	logic                 busy_q, is_sil_q, half_q, out_valid_q;
	logic [FRAME_W-1:0]   shift_q;
	logic [CNT_W-1:0]     bits_left_q;
	logic [SIL_CNT_W-1:0] sil_left_q;
	logic [LEVEL_W-1:0]   level_q;
	logic [TOTAL_W-1:0]   total_q;

	logic [LEVEL_W-1:0]   out_level_q;
	logic [LEN_W-1:0]     out_len_q;
	logic [TOTAL_W-1:0]   out_total_q;
	logic                 out_last_q;

	logic                 advance;
	logic [LEVEL_W-1:0]   toggled, run_level;
	logic [LEN_W-1:0]     run_len;
	logic [TOTAL_W-1:0]   run_total;
	logic                 run_last;

	assign desc_take = !busy_q;
	assign advance   = busy_q && (!out_valid_q || pop);
	assign toggled   = LEVEL_W'(0) - level_q;   // 0x40 <-> 0xC0

	always_comb begin
		if (is_sil_q) begin
			run_level = LEVEL_SILENCE;
			run_last  = (sil_left_q == SIL_CNT_W'(1));
			run_len   = (run_last && (SIL_REM_LEN != '0)) ? SIL_REM_LEN : RUN_MAX_LEN;
		end else begin
			run_level = toggled;
			run_last  = half_q && (bits_left_q == CNT_W'(1));
			run_len   = half_len(speed_mode, shift_q[0], half_q);
		end
		run_total = total_q + TOTAL_W'(run_len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			is_sil_q    <= 1'b0;
			half_q      <= 1'b0;
			shift_q     <= '0;
			bits_left_q <= '0;
			sil_left_q  <= '0;
			level_q     <= LEVEL_RESET;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)  out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;

			if (!busy_q) begin
				if (desc_valid) begin
					busy_q      <= 1'b1;
					is_sil_q    <= desc.is_sil;
					shift_q     <= desc.frame;
					bits_left_q <= desc.nbits;
					half_q      <= 1'b0;
					sil_left_q  <= SIL_CNT_W'(SIL_RUNS);
				end
			end else if (advance) begin
				total_q <= run_total;
				if (run_last) busy_q <= 1'b0;
				if (is_sil_q) begin
					sil_left_q <= sil_left_q - SIL_CNT_W'(1);
				end else begin
					level_q <= toggled;
					half_q  <= !half_q;
					if (half_q) begin
						shift_q     <= {1'b0, shift_q[FRAME_W-1:1]};
						bits_left_q <= bits_left_q - CNT_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_level_q <= run_level;
			out_len_q   <= run_len;
			out_total_q <= run_total;
			out_last_q  <= run_last;
		end
	end

	assign empty        = !out_valid_q;
	assign sample_level = out_level_q;
	assign run_samples  = out_len_q;
	assign sample_total = out_total_q;
	assign last         = out_last_q;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the cassette tape waveform modulator
// Commands go in through the push/full queue. A scoreboard class predicts
// the level runs each command produces and compares every popped run with
// them. Pushes come in random bursts, and pops stall in changing patterns.
// The speed mode is rewritten only while the block is idle.
// ----------------------------------------------------------------------------

module tb_top;
	import ctwm_pkg::*;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [LEN_W-1:0]   len;
		logic [TOTAL_W-1:0] total;
		logic               last;
	} tape_run_t;

	class tape_scoreboard;
		logic [1:0]         speed_mode;
		logic [LEVEL_W-1:0] half_level;
		logic [TOTAL_W-1:0] emitted;
		tape_run_t          runs_due[$];
		int                 errors;
		int                 runs_seen;

		function new();
			speed_mode = MODE_RESET;
			half_level = LEVEL_RESET;
			emitted    = '0;
			errors     = 0;
			runs_seen  = 0;
		endfunction

		function void set_mode(logic [1:0] m);
			speed_mode = m;
		endfunction

		function void add_run(logic [LEVEL_W-1:0] lvl, logic [LEN_W-1:0] n);
			tape_run_t r;
			emitted = emitted + TOTAL_W'(n);
			r.level = lvl;
			r.len   = n;
			r.total = emitted;
			r.last  = 1'b0;
			runs_due.push_back(r);
		endfunction

		// level swings between 0x40 and 0xC0 on every half-cycle
		function void add_half(logic [LEN_W-1:0] n);
			half_level = LEVEL_W'(9'd256 - {1'b0, half_level});
			add_run(half_level, n);
		endfunction

		function void add_bit(logic one);
			logic [LEN_W-1:0] first_len;
			logic [LEN_W-1:0] second_len;
			case (speed_mode)
				MODE_4800: begin
					first_len  = LEN_W'(1);
					second_len = one ? LEN_W'(1) : LEN_W'(2);
				end
				MODE_8000: begin
					first_len  = one ? LEN_W'(1) : LEN_W'(2);
					second_len = one ? LEN_W'(2) : LEN_W'(3);
				end
				default: begin   // 11025 Hz, and code three acts the same
					first_len  = one ? LEN_W'(2) : LEN_W'(3);
					second_len = one ? LEN_W'(2) : LEN_W'(4);
				end
			endcase
			add_half(first_len);
			add_half(second_len);
		endfunction

		// note an accepted command and queue the runs it must produce
		function void note_command(cmd_t c, logic [7:0] data, logic [CNT_W-1:0] cnt);
			int before_n;
			int nbits;
			int left;
			before_n = runs_due.size();
			case (c)
				CMD_BYTE: begin
					add_bit(1'b1);
					add_bit(1'b1);
					for (int i = 0; i < 8; i++)
						add_bit(data[i]);
					add_bit(1'b0);
				end
				CMD_ZERO: begin
					nbits = (cnt > MAX_ZERO_BITS) ? MAX_ZERO_BITS : int'(cnt);
					for (int i = 0; i < nbits; i++)
						add_bit(1'b0);
				end
				CMD_SILENCE: begin
					left = SILENCE_SAMPLES;
					while (left > RUN_MAX) begin
						add_run(LEVEL_SILENCE, RUN_MAX_LEN);
						left -= RUN_MAX;
					end
					if (left > 0)
						add_run(LEVEL_SILENCE, LEN_W'(left));
				end
				default: ;   // no-op command
			endcase
			if (runs_due.size() > before_n)
				runs_due[runs_due.size()-1].last = 1'b1;
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			if (errors < 50)
				$display("mismatch at run %0d: %s got 'h%0h want 'h%0h",
					runs_seen, what, got, want);
			errors++;
		endtask

		task check_run(logic [LEVEL_W-1:0] lvl, logic [LEN_W-1:0] n,
		               logic [TOTAL_W-1:0] tot, logic lst);
			tape_run_t w;
			if (runs_due.size() == 0) begin
				report("run with nothing pending, level", 32'(lvl), 32'h0);
			end else begin
				w = runs_due.pop_front();
				if (lvl !== w.level) report("sample_level", 32'(lvl), 32'(w.level));
				if (n   !== w.len)   report("run_samples", 32'(n), 32'(w.len));
				if (tot !== w.total) report("sample_total", tot, w.total);
				if (lst !== w.last)  report("last", 32'(lst), 32'(w.last));
			end
			runs_seen++;
		endtask
	endclass

	localparam int QUIET_LIMIT  = 3000;  // cycles without any handshake
	localparam int IDLE_CYCLES  = 120;   // settle time after the last run
	localparam int PHASE_ITEMS  = 36;    // counted items per random phase
	localparam int STYLE_CYCLES = 300;   // receiver keeps a stall style this long

	// unused speed code, expected to act as the 11025 Hz mode
	localparam logic [1:0] MODE_SPARE = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  cmd = CMD_NONE;
	logic [7:0]  byte_value = '0;
	logic [5:0]  bit_count = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  sample_level;
	logic [13:0] run_samples;
	logic [31:0] sample_total;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_data = MODE_RESET;

	tape_scoreboard tape_sb = new();

	cassette_tape_waveform_modulator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.cmd          (cmd),
		.byte_value   (byte_value),
		.bit_count    (bit_count),
		.empty        (empty),
		.pop          (pop),
		.sample_level (sample_level),
		.run_samples  (run_samples),
		.sample_total (sample_total),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Monitor: all handshakes are sampled at the rising edge. Inputs are
	// driven with NBAs, so the values read here are the pre-edge ones.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				tape_sb.check_run(sample_level, run_samples, sample_total, last);
			if (push && !full)
				tape_sb.note_command(cmd_t'(cmd), byte_value, bit_count);
			if (cfg_valid && cfg_ready)
				tape_sb.set_mode(cfg_data);
		end
	end

	// watchdog: a long stretch with no handshake at all means a hang
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Receiver: pop follows a stall style that is redrawn at random whenever
	// its age reaches STYLE_CYCLES - always ready, coin flip, or long random stalls.
	// ---------------------------------------------------------------------
	int       style_age = 0;
	int       stall_left = 0;
	int unsigned pop_style = 0;
	always @(posedge clk) begin
		if (style_age >= STYLE_CYCLES) begin
			style_age <= 0;
			pop_style <= $urandom_range(0, 2);
		end else begin
			style_age <= style_age + 1;
		end
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			pop <= 1'b0;
		end else begin
			case (pop_style)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom_range(0, 1));
				default: begin
					if ($urandom_range(0, 7) == 0) begin
						stall_left <= $urandom_range(5, 40);
						pop <= 1'b0;
					end else begin
						pop <= 1'b1;
					end
				end
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Sender tasks
	// ---------------------------------------------------------------------

	// push one command; push stays high on return when hold is set, so the
	// caller must push again right away in that case
	task send_command(logic [1:0] c, logic [7:0] data, logic [5:0] cnt, bit hold);
		push       <= 1'b1;
		cmd        <= c;
		byte_value <= data;
		bit_count  <= cnt;
		do @(posedge clk); while (full);
		if (!hold)
			push <= 1'b0;
	endtask

	// wait until every expected run has popped, then idle a while so the
	// block sits empty
	task wait_drained();
		do @(posedge clk); while (tape_sb.runs_due.size() != 0);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task write_speed(logic [1:0] m);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic bit makes_runs(logic [1:0] c, logic [5:0] cnt);
		return (c == CMD_BYTE) || (c == CMD_SILENCE) || (c == CMD_ZERO && cnt != 0);
	endfunction

	// mostly bytes and zero runs; some silence; the rest is no-ops and
	// oversized bit counts
	task pick_command(output logic [1:0] c, output logic [7:0] data,
	                  output logic [5:0] cnt);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		data = 8'($urandom_range(0, 255));
		cnt  = 6'($urandom_range(0, 63));
		if (roll < 45) begin
			c = CMD_BYTE;
		end else if (roll < 80) begin
			c   = CMD_ZERO;
			cnt = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(1, 32))
			                                  : 6'($urandom_range(1, 6));
		end else if (roll < 88) begin
			c = CMD_SILENCE;
		end else if (roll < 92) begin
			c = CMD_NONE;
		end else if (roll < 96) begin
			c   = CMD_ZERO;
			cnt = '0;
		end else begin
			c   = CMD_ZERO;
			cnt = 6'($urandom_range(33, 63));   // saturates at the max bit count
		end
	endtask

	// random traffic in bursts until the wanted number of run-producing
	// items got in; optionally pause once halfway for a full drain
	task random_phase(int target, bit drain_midway);
		int          counted;
		int unsigned burst_len;
		int unsigned gap;
		bit          paused;
		logic [1:0]  c;
		logic [7:0]  data;
		logic [5:0]  cnt;
		counted = 0;
		paused  = 0;
		while (counted < target) begin
			burst_len = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			for (int k = 0; k < burst_len; k++) begin
				pick_command(c, data, cnt);
				if (makes_runs(c, cnt))
					counted++;
				send_command(c, data, cnt, (k < burst_len - 1) || (gap == 0));
			end
			if (gap == 0) begin
				// push is still high: keep the stream going
				continue;
			end
			repeat (gap) @(posedge clk);
			if (drain_midway && !paused && counted >= target / 2) begin
				paused = 1;
				wait_drained();
			end
		end
		// a burst may end with push held high; drop it
		if (gap == 0)
			push <= 1'b0;
	endtask

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	logic [1:0] mode_plan[6] = '{MODE_4800, MODE_8000, MODE_SPARE, MODE_11025,
	                             MODE_4800, MODE_8000};

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset speed mode: data extremes, every command,
		// zero and oversized bit counts, no-op command
		send_command(CMD_BYTE,    8'h00, 6'd0,  1);
		send_command(CMD_BYTE,    8'hFF, 6'd63, 1);
		send_command(CMD_BYTE,    8'hA5, 6'd21, 1);
		send_command(CMD_BYTE,    8'h5A, 6'd42, 1);
		send_command(CMD_ZERO,    8'hFF, 6'd1,  1);
		send_command(CMD_ZERO,    8'h00, 6'd32, 1);
		send_command(CMD_ZERO,    8'h3C, 6'd33, 1);
		send_command(CMD_ZERO,    8'hC3, 6'd63, 1);
		send_command(CMD_ZERO,    8'h81, 6'd0,  1);
		send_command(CMD_SILENCE, 8'hFF, 6'd63, 1);
		send_command(CMD_NONE,    8'hFF, 6'd63, 1);
		send_command(CMD_NONE,    8'h00, 6'd0,  1);
		send_command(CMD_BYTE,    8'h01, 6'd1,  1);
		send_command(CMD_SILENCE, 8'h00, 6'd0,  1);
		send_command(CMD_BYTE,    8'h80, 6'd32, 0);
		wait_drained();

		// random phases, each under its own speed mode
		for (int p = 0; p < 6; p++) begin
			write_speed(mode_plan[p]);
			random_phase(PHASE_ITEMS, p == 2);
			wait_drained();
		end

		if (tape_sb.errors == 0 && tape_sb.runs_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
